>>> hw/rtl/bdq_pkg.sv
package bdq_pkg;

   // Fixed field widths of the channels
   localparam int REQ_TYPE_W = 3;
   localparam int WORD_W     = 32;
   localparam int CNT_W      = 7;
   localparam int STATUS_W   = 2;

   // Request codes as they arrive on the request channel
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_WALK_FWD   = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_WALK_BWD   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_LENGTH     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_PUSH_BACK,
      CMD_PUSH_FRONT,
      CMD_WALK_FWD,
      CMD_WALK_BWD,
      CMD_LENGTH
   } cmd_kind_type;

endpackage

>>> hw/rtl/bdq_if.sv
interface bdq_req_if import bdq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic        [REQ_TYPE_W-1:0] req_type;
   logic signed [WORD_W-1:0]     value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [WORD_W-1:0]   data_out;
   logic        [CNT_W-1:0]    count;
   logic        [STATUS_W-1:0] status;
   logic                       is_last;

   modport source (output valid, output data_out, output count, output status,
                   output is_last, input ready);
   modport sink   (input valid, input data_out, input count, input status,
                   input is_last, output ready);
endinterface

>>> hw/rtl/bdq_front.sv
module bdq_front import bdq_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   bdq_req_if.sink               req_chan,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_kind_type          cmd_kind,
   output logic [DATA_WIDTH-1:0] cmd_value
);

   // two-entry command queue
   cmd_kind_type            kind_q [2];
   logic [DATA_WIDTH-1:0]   value_q [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              fill_ff, fill_in;
   logic                    accept;
   logic                    pop;
   cmd_kind_type            kind_dec;

   assign req_chan.ready = (fill_ff != 2'd2);
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (fill_ff != 2'd0);
   assign pop            = cmd_valid && cmd_ready;
   assign cmd_kind       = kind_q[rd_ptr_ff];
   assign cmd_value      = value_q[rd_ptr_ff];

   // unused codes behave as a length query
   always_comb begin
      unique case (req_chan.req_type)
         REQ_PUSH_BACK:  kind_dec = CMD_PUSH_BACK;
         REQ_PUSH_FRONT: kind_dec = CMD_PUSH_FRONT;
         REQ_WALK_FWD:   kind_dec = CMD_WALK_FWD;
         REQ_WALK_BWD:   kind_dec = CMD_WALK_BWD;
         default:        kind_dec = CMD_LENGTH;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({accept, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_q[wr_ptr_ff]  <= kind_dec;
         value_q[wr_ptr_ff] <= DATA_WIDTH'(req_chan.value);
      end
   end

endmodule

>>> hw/rtl/bdq_back.sv
module bdq_back import bdq_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_kind_type          cmd_kind,
   input  logic [DATA_WIDTH-1:0] cmd_value,
   bdq_rsp_if.source             rsp_chan
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } back_state_type;

   logic [DATA_WIDTH-1:0] entry_mem [CAPACITY];

   back_state_type               state_ff, state_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             cursor_ff, cursor_in;
   logic [IDX_W-1:0]             ptr_ff, ptr_in;
   logic                         fwd_ff, fwd_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_walk_ff, rsp_walk_in;
   logic [CNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   logic                         out_free;
   logic                         full;
   logic                         empty;
   logic [CNT_W-1:0]             tail_sum;
   logic [CNT_W-1:0]             last_sum;
   logic [IDX_W-1:0]             tail_idx;
   logic [IDX_W-1:0]             last_idx;
   logic [IDX_W-1:0]             head_dec;
   logic [IDX_W-1:0]             ptr_next;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   // ring positions: sums stay below twice the capacity
   always_comb begin
      tail_sum = CNT_W'(head_ff) + count_ff;
      last_sum = CNT_W'(head_ff) + count_ff - CNT_W'(1);
      if (tail_sum >= CNT_W'(CAPACITY)) begin
         tail_idx = IDX_W'(tail_sum - CNT_W'(CAPACITY));
      end else begin
         tail_idx = IDX_W'(tail_sum);
      end
      if (last_sum >= CNT_W'(CAPACITY)) begin
         last_idx = IDX_W'(last_sum - CNT_W'(CAPACITY));
      end else begin
         last_idx = IDX_W'(last_sum);
      end
      head_dec = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - IDX_W'(1);
      if (fwd_ff) begin
         ptr_next = (ptr_ff == IDX_W'(CAPACITY - 1)) ? '0 : ptr_ff + IDX_W'(1);
      end else begin
         ptr_next = (ptr_ff == '0) ? IDX_W'(CAPACITY - 1) : ptr_ff - IDX_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      ptr_in        = ptr_ff;
      fwd_in        = fwd_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_walk_in   = rsp_walk_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_idx;
      rd_en         = 1'b0;
      rd_addr       = ptr_next;

      unique case (state_ff)
         ST_IDLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b0;
            end
            if (cmd_valid && cmd_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_walk_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_count_in  = count_ff;
               unique case (cmd_kind)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_count_in = count_ff + CNT_W'(1);
                        if (cmd_kind == CMD_PUSH_FRONT) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end
                     end
                  end
                  CMD_WALK_FWD, CMD_WALK_BWD: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = (cmd_kind == CMD_WALK_FWD) ? head_ff : last_idx;
                        ptr_in      = rd_addr;
                        fwd_in      = (cmd_kind == CMD_WALK_FWD);
                        cursor_in   = '0;
                        rsp_walk_in = 1'b1;
                        rsp_last_in = (count_ff == CNT_W'(1));
                        state_in    = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (rsp_chan.ready) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  rsp_walk_in  = 1'b0;
                  cursor_in    = '0;
                  state_in     = ST_IDLE;
               end else begin
                  // fetch the next entry while the current one leaves
                  rd_en       = 1'b1;
                  rd_addr     = ptr_next;
                  ptr_in      = ptr_next;
                  cursor_in   = cursor_ff + CNT_W'(1);
                  rsp_last_in = ((cursor_ff + CNT_W'(2)) == count_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         fwd_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_walk_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_walk_ff  <= rsp_walk_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= cmd_value;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = rsp_walk_ff ? WORD_W'(rd_data_ff) : '0;
   assign rsp_chan.count    = rsp_count_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.is_last  = rsp_last_ff;

endmodule

>>> hw/rtl/bounded_deque_with_traversal.sv
// Bounded double-ended queue of signed words with in-order traversal.
// req_chan takes one request item per handshake: push back, push front,
// walk forward, walk backward or length query (unused codes act as a
// length query). rsp_chan returns result items: data_out, count, status
// and is_last, which marks the final result of each request.
// Pushes and length queries give one result, passing through the command
// queue and then the result register; back to back they sustain one
// request per cycle while rsp_chan is ready. A walk of N stored entries
// gives N results, the first after the command queue and the entry read,
// then one per cycle while rsp_chan is ready: the back end streams from
// its entry memory, fetching the next entry as the current result leaves.
// After the last result the back end returns to idle with the result
// register empty before it takes the next command; a two-item queue in
// the front keeps accepting requests meanwhile.
// Push to a full queue is dropped with status full; walking an empty queue
// gives one result with status empty. Reset (synchronous) empties the
// queue and clears head and count; the entry memory needs no clearing.
// When rsp_chan stalls, the result register holds its item, the back end
// waits, and req_chan.ready drops once the command queue is full.
module bounded_deque_with_traversal import bdq_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   // front to back command link
   logic                  cmd_valid;
   logic                  cmd_ready;
   cmd_kind_type          cmd_kind;
   logic [DATA_WIDTH-1:0] cmd_value;

   // front: accept and classify requests into the command queue
   bdq_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_kind  (cmd_kind),
      .cmd_value (cmd_value)
   );

   // back: ring storage, head/count, walk sequencer, result register
   bdq_back #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_kind  (cmd_kind),
      .cmd_value (cmd_value),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> hw/rtl/bdq_checker.sv
module bdq_checker import bdq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [WORD_W-1:0]   rsp_data_out,
   input logic        [CNT_W-1:0]    rsp_count,
   input logic        [STATUS_W-1:0] rsp_status,
   input logic                       rsp_is_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data_out) && $stable(rsp_count)
                                  && $stable(rsp_status) && $stable(rsp_is_last))
      else $error("result changed while stalled");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_count == CNT_W'(CAPACITY) && rsp_is_last && rsp_data_out == '0)
      else $error("full status with wrong count or payload");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_count == '0 && rsp_is_last && rsp_data_out == '0)
      else $error("empty status with wrong count or payload");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("count above capacity");

endmodule

bind bounded_deque_with_traversal bdq_checker #(
   .CAPACITY (CAPACITY)
) u_bdq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_count    (rsp_chan.count),
   .rsp_status   (rsp_chan.status),
   .rsp_is_last  (rsp_chan.is_last)
);
